>>> sv/scar_pkg.sv
// shared types, constants and arithmetic helpers for the comb/allpass reverb
package scar_pkg;

  localparam int SAMP_W     = 24;
  localparam int DATA_W     = 32;
  localparam int COEF_W     = 16;
  localparam int GAIN_W     = 17;
  localparam int PDL_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int MUL_A_W    = 33;
  localparam int MUL_B_W    = 19;
  localparam int ACC_W      = 52;
  localparam int WIDE_W     = 40;
  localparam int CSUM_W     = 36;

  localparam int Q16_ONE     = 65536;
  localparam int DRY_SCALE   = 45875;
  localparam int SIDE_SPREAD = 23;

  localparam logic [CFG_IDX_W-1:0] REG_ROOM  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WET   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PDL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd5;

  localparam logic [COEF_W-1:0] ROOM_RST  = 16'd41288;
  localparam logic [COEF_W-1:0] DAMP_RST  = 16'd32768;
  localparam logic [GAIN_W-1:0] WET_RST   = 17'd21845;
  localparam logic [GAIN_W-1:0] WIDTH_RST = 17'd65536;

  typedef struct packed {
    logic go;
    logic clr;
  } mac_ctl_t;

  function automatic logic [10:0] comb_tune(input logic [3:0] i);
    logic [10:0] v;
    case (i)
      4'd0:    v = 11'd1116;
      4'd1:    v = 11'd1188;
      4'd2:    v = 11'd1277;
      4'd3:    v = 11'd1356;
      4'd4:    v = 11'd1422;
      4'd5:    v = 11'd1491;
      4'd6:    v = 11'd1557;
      4'd7:    v = 11'd1617;
      4'd8:    v = 11'd1053;
      4'd9:    v = 11'd1087;
      4'd10:   v = 11'd1151;
      4'd11:   v = 11'd1213;
      4'd12:   v = 11'd1249;
      4'd13:   v = 11'd1307;
      4'd14:   v = 11'd1381;
      default: v = 11'd1453;
    endcase
    return v;
  endfunction

  function automatic logic [9:0] ap_tune(input logic [2:0] i);
    logic [9:0] v;
    case (i)
      3'd0:    v = 10'd556;
      3'd1:    v = 10'd441;
      3'd2:    v = 10'd341;
      3'd3:    v = 10'd225;
      3'd4:    v = 10'd179;
      3'd5:    v = 10'd142;
      3'd6:    v = 10'd113;
      default: v = 10'd89;
    endcase
    return v;
  endfunction

  function automatic logic signed [WIDE_W-1:0] rnd16(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] s;
    t = a + $signed(ACC_W'(32768));
    s = t >>> 16;
    return s[WIDE_W-1:0];
  endfunction

  function automatic logic signed [WIDE_W-1:0] rnd17(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] t;
    logic signed [ACC_W-1:0] s;
    t = a + $signed(ACC_W'(65536));
    s = t >>> 17;
    return s[WIDE_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if ((&x[WIDE_W-1:DATA_W-1]) || !(|x[WIDE_W-1:DATA_W-1])) r = x[DATA_W-1:0];
    else if (x[WIDE_W-1]) r = 32'sh8000_0000;
    else r = 32'sh7fff_ffff;
    return r;
  endfunction

  function automatic logic signed [SAMP_W-1:0] sat24(input logic signed [WIDE_W-1:0] x);
    logic signed [SAMP_W-1:0] r;
    if ((&x[WIDE_W-1:SAMP_W-1]) || !(|x[WIDE_W-1:SAMP_W-1])) r = x[SAMP_W-1:0];
    else if (x[WIDE_W-1]) r = 24'sh80_0000;
    else r = 24'sh7f_ffff;
    return r;
  endfunction

  function automatic logic signed [WIDE_W-1:0] ext32(input logic signed [DATA_W-1:0] v);
    return {{(WIDE_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  function automatic logic signed [SAMP_W:0] avg24(input logic signed [SAMP_W-1:0] a,
                                                  input logic signed [SAMP_W-1:0] b);
    logic signed [SAMP_W:0] s;
    s = {a[SAMP_W-1], a} + {b[SAMP_W-1], b};
    return s >>> 1;
  endfunction

endpackage

>>> sv/scar_ram.sv
// single write port, single registered read port delay-line memory
module scar_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/scar_mac.sv
// shared multiply-accumulate unit: registered product, then accumulate
module scar_mac import scar_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mac_ctl_t                   ctl,
  input  logic signed [MUL_A_W-1:0]  a,
  input  logic signed [MUL_B_W-1:0]  b,
  output logic signed [ACC_W-1:0]    acc
);

  logic signed [ACC_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  mac_ctl_t                ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= a * b;
    acc_r  <= acc_nxt;
  end

  always_comb begin
    acc_nxt = acc_r;
    if (ctl_r.go) begin
      acc_nxt = (ctl_r.clr ? '0 : acc_r) + prod_r;
    end
  end

  assign acc = acc_r;

endmodule

>>> sv/stereo_comb_allpass_reverb_top.sv
// stereo comb/allpass reverb: sequencer, delay-line memories and shared mac
//
//  port group | direction | handshake          | word
//  in_        | input     | in_valid/in_ready   | left_in, right_in (Q1.23)
//  out_       | output    | out_valid/out_ready | left_out, right_out (Q1.23)
//  cfg_       | input     | cfg_we              | cfg_index, cfg_data
//
// each word runs through the comb and allpass steps, plus the pre-delay read, write and
// remainder steps when pre-delay is on; the single mac sets the pace
// after reset a clearing pass over the largest memory's address range zeroes all delay
// lines; in_ready stays low until it ends
// a finished word waits in the output register; the next word is accepted meanwhile
module stereo_comb_allpass_reverb_top import scar_pkg::*; #(
  parameter int COMB_DEPTH     = 2048,
  parameter int ALLPASS_DEPTH  = 1024,
  parameter int PREDELAY_DEPTH = 8192,
  parameter int NUM_COMBS      = 8,
  parameter int NUM_ALLPASS    = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [SAMP_W-1:0]     in_left_in,
  input  logic signed [SAMP_W-1:0]     in_right_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [SAMP_W-1:0]     out_left_out,
  output logic signed [SAMP_W-1:0]     out_right_out,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int CM_SIZE = 2 * NUM_COMBS * COMB_DEPTH;
  localparam int AP_SIZE = 2 * NUM_ALLPASS * ALLPASS_DEPTH;
  localparam int CLR_LEN = (CM_SIZE > AP_SIZE) ?
                           ((CM_SIZE > PREDELAY_DEPTH) ? CM_SIZE : PREDELAY_DEPTH) :
                           ((AP_SIZE > PREDELAY_DEPTH) ? AP_SIZE : PREDELAY_DEPTH);
  localparam int CLR_W   = $clog2(CLR_LEN + 1);
  localparam int CA_W    = $clog2(CM_SIZE);
  localparam int AA_W    = $clog2(AP_SIZE);
  localparam int CP_W    = $clog2(COMB_DEPTH);
  localparam int AP_W    = $clog2(ALLPASS_DEPTH);
  localparam int PP_W    = $clog2(PREDELAY_DEPTH);
  localparam int DV_W    = PP_W + 1;
  localparam int REM_W   = PP_W + 1;
  localparam int MC_W    = $clog2(DV_W);
  localparam int CI_W    = (NUM_COMBS > 1) ? $clog2(NUM_COMBS) : 1;
  localparam int AI_W    = (NUM_ALLPASS > 1) ? $clog2(NUM_ALLPASS) : 1;
  localparam int K_W     = $clog2(2 * NUM_COMBS);
  localparam int AK_W    = $clog2(2 * NUM_ALLPASS);

  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] ST_CLEAR  = 5'd0;
  localparam logic [ST_W-1:0] ST_IDLE   = 5'd1;
  localparam logic [ST_W-1:0] ST_PD_RD  = 5'd2;
  localparam logic [ST_W-1:0] ST_PD_WR  = 5'd3;
  localparam logic [ST_W-1:0] ST_PD_MOD = 5'd4;
  localparam logic [ST_W-1:0] ST_C_RD   = 5'd5;
  localparam logic [ST_W-1:0] ST_C_M1   = 5'd6;
  localparam logic [ST_W-1:0] ST_C_M2   = 5'd7;
  localparam logic [ST_W-1:0] ST_C_W1   = 5'd8;
  localparam logic [ST_W-1:0] ST_C_LP   = 5'd9;
  localparam logic [ST_W-1:0] ST_C_W2   = 5'd10;
  localparam logic [ST_W-1:0] ST_C_WR   = 5'd11;
  localparam logic [ST_W-1:0] ST_A_RD   = 5'd12;
  localparam logic [ST_W-1:0] ST_A_OP   = 5'd13;
  localparam logic [ST_W-1:0] ST_MX0    = 5'd14;
  localparam logic [ST_W-1:0] ST_MX1    = 5'd15;
  localparam logic [ST_W-1:0] ST_MX2    = 5'd16;
  localparam logic [ST_W-1:0] ST_MX3    = 5'd17;
  localparam logic [ST_W-1:0] ST_MX4    = 5'd18;
  localparam logic [ST_W-1:0] ST_MX5    = 5'd19;
  localparam logic [ST_W-1:0] ST_MX6    = 5'd20;
  localparam logic [ST_W-1:0] ST_MX7    = 5'd21;
  localparam logic [ST_W-1:0] ST_MX8    = 5'd22;
  localparam logic [ST_W-1:0] ST_MX9    = 5'd23;
  localparam logic [ST_W-1:0] ST_MX10   = 5'd24;
  localparam logic [ST_W-1:0] ST_MX11   = 5'd25;
  localparam logic [ST_W-1:0] ST_MX12   = 5'd26;
  localparam logic [ST_W-1:0] ST_MX13   = 5'd27;
  localparam logic [ST_W-1:0] ST_MX14   = 5'd28;

  // configuration
  logic [COEF_W-1:0] room_r, damp_r;
  logic [GAIN_W-1:0] wet_r, width_r;
  logic [PDL_W-1:0]  pdlen_r;
  logic              stereo_r;

  // control
  logic [ST_W-1:0]  st_r, st_nxt;
  logic [CLR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [PP_W-1:0]  pp_r, pp_nxt;
  logic             side_r, side_nxt;
  logic [CI_W-1:0]  ci_r, ci_nxt;
  logic [AI_W-1:0]  ai_r, ai_nxt;
  logic [MC_W-1:0]  mcnt_r, mcnt_nxt;
  logic signed [DATA_W-1:0] lp_r [2*NUM_COMBS];
  logic signed [DATA_W-1:0] lp_nxt [2*NUM_COMBS];
  logic [CP_W-1:0]  cpos_r [2*NUM_COMBS];
  logic [CP_W-1:0]  cpos_nxt [2*NUM_COMBS];
  logic [AP_W-1:0]  apos_r [2*NUM_ALLPASS];
  logic [AP_W-1:0]  apos_nxt [2*NUM_ALLPASS];

  // datapath
  logic signed [SAMP_W-1:0] xl_r, xl_nxt, xr_r, xr_nxt, rraw_r, rraw_nxt;
  logic                     istereo_r, istereo_nxt;
  logic [PP_W-1:0]          pdl_r, pdl_nxt;
  logic signed [SAMP_W:0]   vin_r, vin_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;
  logic [DV_W-1:0]          dvd_r, dvd_nxt;
  logic signed [CSUM_W-1:0] csum_r, csum_nxt;
  logic signed [DATA_W-1:0] x_r, x_nxt, suml_r, suml_nxt, sumr_r, sumr_nxt;
  logic signed [DATA_W-1:0] wl_r, wl_nxt, wr_r, wr_nxt;
  logic [GAIN_W-1:0]        dry_r, dry_nxt;
  logic signed [SAMP_W-1:0] yl_r, yl_nxt;
  logic signed [SAMP_W-1:0] outl_r, outl_nxt, outr_r, outr_nxt;

  // shared mac
  mac_ctl_t                mac_ctl;
  logic signed [MUL_A_W-1:0] mac_a;
  logic signed [MUL_B_W-1:0] mac_b;
  logic signed [ACC_W-1:0]   mac_acc;

  // memories
  logic              cm_we, cm_re, ap_we, ap_re, pd_we, pd_re;
  logic [CA_W-1:0]   cm_waddr, cm_raddr;
  logic [AA_W-1:0]   ap_waddr, ap_raddr;
  logic [PP_W-1:0]   pd_waddr;
  logic [DATA_W-1:0] cm_wdata, cm_rdata, ap_wdata, ap_rdata;
  logic [SAMP_W-1:0] pdl_wdata, pdr_wdata, pdl_rdata, pdr_rdata;

  // helpers
  logic [K_W-1:0]           ck;
  logic [AK_W-1:0]          ak;
  logic [14:0]              craw;
  logic [CP_W-1:0]          clen, cpos_inc;
  logic [11:0]              araw;
  logic [AP_W-1:0]          alen, apos_inc;
  logic [PP_W-1:0]          pdl_c;
  logic [GAIN_W-1:0]        wsat, gsat;
  logic [GAIN_W:0]          wplus;
  logic [GAIN_W-1:0]        wminus;
  logic signed [WIDE_W-1:0] r16, r17, vin_w;
  logic signed [DATA_W-1:0] lpv, ap_o;
  logic [REM_W-1:0]         rem_sh;
  logic [GAIN_W-1:0]        dry_v;

  assign in_ready      = (st_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_left_out  = outl_r;
  assign out_right_out = outr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      room_r   <= ROOM_RST;
      damp_r   <= DAMP_RST;
      wet_r    <= WET_RST;
      width_r  <= WIDTH_RST;
      pdlen_r  <= '0;
      stereo_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROOM:  room_r   <= cfg_data[COEF_W-1:0];
        REG_DAMP:  damp_r   <= cfg_data[COEF_W-1:0];
        REG_WET:   wet_r    <= cfg_data;
        REG_WIDTH: width_r  <= cfg_data;
        REG_PDL:   pdlen_r  <= cfg_data[PDL_W-1:0];
        REG_MODE:  stereo_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    ck   = K_W'(side_r ? (NUM_COMBS + int'(ci_r)) : int'(ci_r));
    ak   = AK_W'(side_r ? (NUM_ALLPASS + int'(ai_r)) : int'(ai_r));
    craw = 15'(comb_tune(4'(ci_r))) + (side_r ? 15'(SIDE_SPREAD) : 15'd0);
    if (int'(craw) > COMB_DEPTH - 1) clen = CP_W'(COMB_DEPTH - 1);
    else clen = CP_W'(craw);
    if (clen == '0) clen = CP_W'(1);
    araw = 12'(ap_tune(3'(ai_r))) + (side_r ? 12'(SIDE_SPREAD) : 12'd0);
    if (int'(araw) > ALLPASS_DEPTH - 1) alen = AP_W'(ALLPASS_DEPTH - 1);
    else alen = AP_W'(araw);
    if (alen == '0) alen = AP_W'(1);
    cpos_inc = ((CP_W+1)'(cpos_r[ck]) + 1'b1 == (CP_W+1)'(clen)) ? '0 : cpos_r[ck] + 1'b1;
    apos_inc = ((AP_W+1)'(apos_r[ak]) + 1'b1 == (AP_W+1)'(alen)) ? '0 : apos_r[ak] + 1'b1;
    if (int'(pdlen_r) > PREDELAY_DEPTH - 1) pdl_c = PP_W'(PREDELAY_DEPTH - 1);
    else pdl_c = PP_W'(pdlen_r);
    wsat   = (width_r > 17'(Q16_ONE)) ? 17'(Q16_ONE) : width_r;
    gsat   = (wet_r > 17'(Q16_ONE)) ? 17'(Q16_ONE) : wet_r;
    wplus  = 18'(Q16_ONE) + {1'b0, wsat};
    wminus = 17'(Q16_ONE) - wsat;
    r16    = rnd16(mac_acc);
    r17    = rnd17(mac_acc);
    vin_w  = {{(WIDE_W-SAMP_W-1){vin_r[SAMP_W]}}, vin_r};
    lpv    = sat32(r16);
    ap_o   = ap_rdata;
    rem_sh = {rem_r[REM_W-2:0], dvd_r[DV_W-1]};
    dry_v  = 17'(Q16_ONE) - r16[GAIN_W-1:0];
    cm_raddr = CA_W'(int'(ck) * COMB_DEPTH) + CA_W'(cpos_r[ck]);
    ap_raddr = AA_W'(int'(ak) * ALLPASS_DEPTH) + AA_W'(apos_r[ak]);
  end

  always_comb begin
    st_nxt        = st_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r;
    pp_nxt        = pp_r;
    side_nxt      = side_r;
    ci_nxt        = ci_r;
    ai_nxt        = ai_r;
    mcnt_nxt      = mcnt_r;
    lp_nxt        = lp_r;
    cpos_nxt      = cpos_r;
    apos_nxt      = apos_r;
    xl_nxt        = xl_r;
    xr_nxt        = xr_r;
    rraw_nxt      = rraw_r;
    istereo_nxt   = istereo_r;
    pdl_nxt       = pdl_r;
    vin_nxt       = vin_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    csum_nxt      = csum_r;
    x_nxt         = x_r;
    suml_nxt      = suml_r;
    sumr_nxt      = sumr_r;
    wl_nxt        = wl_r;
    wr_nxt        = wr_r;
    dry_nxt       = dry_r;
    yl_nxt        = yl_r;
    outl_nxt      = outl_r;
    outr_nxt      = outr_r;
    mac_ctl       = '0;
    mac_a         = '0;
    mac_b         = '0;
    cm_we         = 1'b0;
    cm_re         = 1'b0;
    cm_waddr      = cm_raddr;
    cm_wdata      = '0;
    ap_we         = 1'b0;
    ap_re         = 1'b0;
    ap_waddr      = ap_raddr;
    ap_wdata      = '0;
    pd_we         = 1'b0;
    pd_re         = 1'b0;
    pd_waddr      = pp_r;
    pdl_wdata     = xl_r;
    pdr_wdata     = xr_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      ST_CLEAR: begin
        cm_we       = clr_cnt_r < CLR_W'(CM_SIZE);
        ap_we       = clr_cnt_r < CLR_W'(AP_SIZE);
        pd_we       = clr_cnt_r < CLR_W'(PREDELAY_DEPTH);
        cm_waddr    = CA_W'(clr_cnt_r);
        ap_waddr    = AA_W'(clr_cnt_r);
        pd_waddr    = PP_W'(clr_cnt_r);
        pdl_wdata   = '0;
        pdr_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_W'(CLR_LEN - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          xl_nxt      = in_left_in;
          xr_nxt      = stereo_r ? in_right_in : in_left_in;
          rraw_nxt    = in_right_in;
          istereo_nxt = stereo_r;
          pdl_nxt     = pdl_c;
          side_nxt    = 1'b0;
          ci_nxt      = '0;
          csum_nxt    = '0;
          if (pdl_c == '0) begin
            vin_nxt = avg24(in_left_in, stereo_r ? in_right_in : in_left_in);
            st_nxt  = ST_C_RD;
          end else begin
            st_nxt = ST_PD_RD;
          end
        end
      end
      ST_PD_RD: begin
        pd_re  = 1'b1;
        st_nxt = ST_PD_WR;
      end
      ST_PD_WR: begin
        pd_we    = 1'b1;
        vin_nxt  = avg24(pdl_rdata, pdr_rdata);
        rem_nxt  = '0;
        dvd_nxt  = DV_W'(pp_r) + 1'b1;
        mcnt_nxt = MC_W'(DV_W - 1);
        st_nxt   = ST_PD_MOD;
      end
      ST_PD_MOD: begin
        // restoring remainder, one bit a cycle
        dvd_nxt = dvd_r << 1;
        if (rem_sh >= REM_W'(pdl_r)) rem_nxt = rem_sh - REM_W'(pdl_r);
        else rem_nxt = rem_sh;
        mcnt_nxt = mcnt_r - 1'b1;
        if (mcnt_r == '0) begin
          pp_nxt = PP_W'(rem_nxt);
          st_nxt = ST_C_RD;
        end
      end
      ST_C_RD: begin
        cm_re  = 1'b1;
        st_nxt = ST_C_M1;
      end
      ST_C_M1: begin
        mac_ctl  = '{go: 1'b1, clr: 1'b1};
        mac_a    = {cm_rdata[DATA_W-1], cm_rdata};
        mac_b    = {3'b0, 16'(0)} + MUL_B_W'(17'(Q16_ONE) - {1'b0, damp_r});
        csum_nxt = csum_r + {{(CSUM_W-DATA_W){cm_rdata[DATA_W-1]}}, cm_rdata};
        st_nxt   = ST_C_M2;
      end
      ST_C_M2: begin
        mac_ctl = '{go: 1'b1, clr: 1'b0};
        mac_a   = {lp_r[ck][DATA_W-1], lp_r[ck]};
        mac_b   = {3'b0, damp_r};
        st_nxt  = ST_C_W1;
      end
      ST_C_W1: begin
        st_nxt = ST_C_LP;
      end
      ST_C_LP: begin
        lp_nxt[ck] = lpv;
        mac_ctl    = '{go: 1'b1, clr: 1'b1};
        mac_a      = {lpv[DATA_W-1], lpv};
        mac_b      = {3'b0, room_r};
        st_nxt     = ST_C_W2;
      end
      ST_C_W2: begin
        st_nxt = ST_C_WR;
      end
      ST_C_WR: begin
        cm_we        = 1'b1;
        cm_wdata     = sat32(vin_w + r16);
        cpos_nxt[ck] = cpos_inc;
        if (ci_r == CI_W'(NUM_COMBS - 1)) begin
          ci_nxt = '0;
          ai_nxt = '0;
          x_nxt  = sat32({{(WIDE_W-CSUM_W){csum_r[CSUM_W-1]}}, csum_r});
          st_nxt = ST_A_RD;
        end else begin
          ci_nxt = ci_r + 1'b1;
          st_nxt = ST_C_RD;
        end
      end
      ST_A_RD: begin
        ap_re  = 1'b1;
        st_nxt = ST_A_OP;
      end
      ST_A_OP: begin
        ap_we        = 1'b1;
        ap_wdata     = sat32(ext32(x_r) + ext32(ap_o >>> 1));
        x_nxt        = sat32(ext32(ap_o) - ext32(x_r));
        apos_nxt[ak] = apos_inc;
        if (ai_r == AI_W'(NUM_ALLPASS - 1)) begin
          ai_nxt = '0;
          if (!side_r) begin
            suml_nxt = x_nxt;
            side_nxt = 1'b1;
            csum_nxt = '0;
            st_nxt   = ST_C_RD;
          end else begin
            sumr_nxt = x_nxt;
            st_nxt   = ST_MX0;
          end
        end else begin
          ai_nxt = ai_r + 1'b1;
          st_nxt = ST_A_RD;
        end
      end
      ST_MX0: begin
        mac_ctl = '{go: 1'b1, clr: 1'b1};
        mac_a   = {suml_r[DATA_W-1], suml_r};
        mac_b   = {1'b0, wplus};
        st_nxt  = ST_MX1;
      end
      ST_MX1: begin
        mac_ctl = '{go: 1'b1, clr: 1'b0};
        mac_a   = {sumr_r[DATA_W-1], sumr_r};
        mac_b   = {2'b0, wminus};
        st_nxt  = ST_MX2;
      end
      ST_MX2: begin
        st_nxt = ST_MX3;
      end
      ST_MX3: begin
        wl_nxt  = r17[DATA_W-1:0];
        mac_ctl = '{go: 1'b1, clr: 1'b1};
        mac_a   = {sumr_r[DATA_W-1], sumr_r};
        mac_b   = {1'b0, wplus};
        st_nxt  = ST_MX4;
      end
      ST_MX4: begin
        mac_ctl = '{go: 1'b1, clr: 1'b0};
        mac_a   = {suml_r[DATA_W-1], suml_r};
        mac_b   = {2'b0, wminus};
        st_nxt  = ST_MX5;
      end
      ST_MX5: begin
        st_nxt = ST_MX6;
      end
      ST_MX6: begin
        wr_nxt  = r17[DATA_W-1:0];
        mac_ctl = '{go: 1'b1, clr: 1'b1};
        mac_a   = MUL_A_W'(gsat);
        mac_b   = MUL_B_W'(DRY_SCALE);
        st_nxt  = ST_MX7;
      end
      ST_MX7: begin
        st_nxt = ST_MX8;
      end
      ST_MX8: begin
        dry_nxt = dry_v;
        mac_ctl = '{go: 1'b1, clr: 1'b1};
        mac_a   = {{(MUL_A_W-SAMP_W){xl_r[SAMP_W-1]}}, xl_r};
        mac_b   = {2'b0, dry_v};
        st_nxt  = ST_MX9;
      end
      ST_MX9: begin
        mac_ctl = '{go: 1'b1, clr: 1'b0};
        mac_a   = {wl_r[DATA_W-1], wl_r};
        mac_b   = {2'b0, gsat};
        st_nxt  = ST_MX10;
      end
      ST_MX10: begin
        st_nxt = ST_MX11;
      end
      ST_MX11: begin
        yl_nxt  = sat24(r16);
        mac_ctl = '{go: 1'b1, clr: 1'b1};
        mac_a   = {{(MUL_A_W-SAMP_W){xr_r[SAMP_W-1]}}, xr_r};
        mac_b   = {2'b0, dry_r};
        st_nxt  = ST_MX12;
      end
      ST_MX12: begin
        mac_ctl = '{go: 1'b1, clr: 1'b0};
        mac_a   = {wr_r[DATA_W-1], wr_r};
        mac_b   = {2'b0, gsat};
        st_nxt  = ST_MX13;
      end
      ST_MX13: begin
        st_nxt = ST_MX14;
      end
      ST_MX14: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ready) begin
          outl_nxt      = yl_r;
          outr_nxt      = istereo_r ? sat24(r16) : rraw_r;
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      pp_r        <= '0;
      side_r      <= 1'b0;
      ci_r        <= '0;
      ai_r        <= '0;
      mcnt_r      <= '0;
      for (int i = 0; i < 2 * NUM_COMBS; i++) begin
        lp_r[i]   <= '0;
        cpos_r[i] <= '0;
      end
      for (int i = 0; i < 2 * NUM_ALLPASS; i++) begin
        apos_r[i] <= '0;
      end
    end else begin
      st_r        <= st_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      pp_r        <= pp_nxt;
      side_r      <= side_nxt;
      ci_r        <= ci_nxt;
      ai_r        <= ai_nxt;
      mcnt_r      <= mcnt_nxt;
      lp_r        <= lp_nxt;
      cpos_r      <= cpos_nxt;
      apos_r      <= apos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xl_r      <= xl_nxt;
    xr_r      <= xr_nxt;
    rraw_r    <= rraw_nxt;
    istereo_r <= istereo_nxt;
    pdl_r     <= pdl_nxt;
    vin_r     <= vin_nxt;
    rem_r     <= rem_nxt;
    dvd_r     <= dvd_nxt;
    csum_r    <= csum_nxt;
    x_r       <= x_nxt;
    suml_r    <= suml_nxt;
    sumr_r    <= sumr_nxt;
    wl_r      <= wl_nxt;
    wr_r      <= wr_nxt;
    dry_r     <= dry_nxt;
    yl_r      <= yl_nxt;
    outl_r    <= outl_nxt;
    outr_r    <= outr_nxt;
  end

  scar_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .a     (mac_a),
    .b     (mac_b),
    .acc   (mac_acc)
  );

  scar_ram #(.WIDTH(DATA_W), .DEPTH(CM_SIZE)) u_comb_ram (
    .clk   (clk),
    .we    (cm_we),
    .waddr (cm_waddr),
    .wdata (cm_wdata),
    .re    (cm_re),
    .raddr (cm_raddr),
    .rdata (cm_rdata)
  );

  scar_ram #(.WIDTH(DATA_W), .DEPTH(AP_SIZE)) u_ap_ram (
    .clk   (clk),
    .we    (ap_we),
    .waddr (ap_waddr),
    .wdata (ap_wdata),
    .re    (ap_re),
    .raddr (ap_raddr),
    .rdata (ap_rdata)
  );

  scar_ram #(.WIDTH(SAMP_W), .DEPTH(PREDELAY_DEPTH)) u_pdl_ram (
    .clk   (clk),
    .we    (pd_we),
    .waddr (pd_waddr),
    .wdata (pdl_wdata),
    .re    (pd_re),
    .raddr (pp_r),
    .rdata (pdl_rdata)
  );

  scar_ram #(.WIDTH(SAMP_W), .DEPTH(PREDELAY_DEPTH)) u_pdr_ram (
    .clk   (clk),
    .we    (pd_we),
    .waddr (pd_waddr),
    .wdata (pdr_wdata),
    .re    (pd_re),
    .raddr (pp_r),
    .rdata (pdr_rdata)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a word while a previous one is in flight");

  a_mac_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE || st_r == ST_CLEAR) |-> !mac_ctl.go)
    else $error("mac issued outside of a word");

  a_comb_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cm_we && st_r != ST_CLEAR) |-> (st_r == ST_C_WR))
    else $error("comb line written outside its write step");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MX14 && out_valid_r && !out_ready) |=> (st_r == ST_MX14))
    else $error("result dropped while output register busy");

endmodule
